/* sv/bankers_safety_allocator_macros.svh */
// assertion macros used by the allocator top module
// no dependencies; included by files that carry checks
`ifndef BANKERS_SAFETY_ALLOCATOR_MACROS_SVH
`define BANKERS_SAFETY_ALLOCATOR_MACROS_SVH

// condition must hold on every clock while out of reset
`define BSA_CHECK(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("allocator check failed");

// trigger implies the consequence on the following clock
`define BSA_CHECK_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("allocator sequence check failed");

`endif

/* sv/bsa_pkg.sv */
// shared types, codes and sizes of the banker's safety allocator
// no dependencies
package bsa_pkg;

    localparam int MAX_PROCESSES  = 16;
    localparam int RESOURCE_TYPES = 6;
    localparam int AVAIL_W        = 13;
    localparam int WORK_W         = 14;

    localparam logic [1:0] KIND_SET_AVAIL = 2'd0;
    localparam logic [1:0] KIND_LOAD      = 2'd1;
    localparam logic [1:0] KIND_REQUEST   = 2'd2;
    localparam logic [1:0] KIND_QUERY     = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_OVER_NEED  = 3'd1;
    localparam logic [2:0] ST_MUST_WAIT  = 3'd2;
    localparam logic [2:0] ST_UNSAFE     = 3'd3;
    localparam logic [2:0] ST_ALLOC_MAX  = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX  = 3'd5;

    localparam logic CFG_PROC_COUNT = 1'b0;
    localparam logic CFG_RES_COUNT  = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] process;
        logic [2:0] resource;
        logic [7:0] amount;
        logic [7:0] alloc_amount;
        logic [7:0] req_0;
        logic [7:0] req_1;
        logic [7:0] req_2;
        logic [7:0] req_3;
        logic [7:0] req_4;
        logic [7:0] req_5;
    } cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic       safe;
        logic [3:0] seq_process;
        logic       last;
    } rsp_t;

endpackage

/* sv/bankers_safety_allocator.sv */
// top level of the banker's safety allocator: sequencer, available counts,
// safety walk; depends on bsa_pkg, bsa_store, bsa_outreg and the macro header
//
//  channel   signals                                 direction  handshake
//  cmd       cmd_valid cmd_stall cmd                 in         valid && !stall
//  rsp       rsp_valid rsp_stall rsp                 out        valid && !stall
//  cfg       cfg_valid cfg_ready cfg_index cfg_data  in         valid && ready
//
// set available and index errors go to the result state, load via its check
// state, over-need and must-wait via the request check; results are registered in
// the output register. Query: walk init, walk; request: request check, walk init,
// walk, rollback if unsafe. The walk reads one process row per cycle from the row
// memory, n passes of n processes; then n results if safe, else one. Reset sets
// 1 process, 6 resources, clears the available vector and row-valid bits at once
// a stalled result holds the sequencer only where it has a new result to give
`include "bankers_safety_allocator_macros.svh"
module bankers_safety_allocator #(
    parameter int MAX_PROCESSES  = bsa_pkg::MAX_PROCESSES,
    parameter int RESOURCE_TYPES = bsa_pkg::RESOURCE_TYPES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  bsa_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bsa_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [4:0]    cfg_data
);

    localparam int CAP   = (MAX_PROCESSES < 16) ? MAX_PROCESSES : 16;
    localparam int PAW   = $clog2(MAX_PROCESSES);
    localparam int CW    = $clog2(CAP);
    localparam int HALF  = RESOURCE_TYPES * 8;
    localparam int ROW_W = 2 * HALF;
    localparam int AW    = bsa_pkg::AVAIL_W;
    localparam int WW    = bsa_pkg::WORK_W;

    typedef enum logic [3:0] {
        S_IDLE, S_LD_CHK, S_REQ_CHK, S_WALK_INIT, S_WALK, S_ROLLBACK, S_RESULT, S_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [4:0] pcount_reg;
    logic [2:0] rcount_reg;
    logic [4:0] n_eff;
    logic [2:0] m_eff;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (pcount_reg == 5'd0)
            n_eff = 5'd1;
        else if (32'(pcount_reg) > CAP)
            n_eff = 5'(CAP);
        else
            n_eff = pcount_reg;
        if (rcount_reg == 3'd0)
            m_eff = 3'd1;
        else if (32'(rcount_reg) > RESOURCE_TYPES)
            m_eff = 3'(RESOURCE_TYPES);
        else
            m_eff = rcount_reg;
    end

    // latched item and working state
    bsa_pkg::cmd_t      cmd_reg;
    logic               is_req_reg;
    logic [2:0]         status_reg;
    logic signed [AW-1:0] avail_reg [RESOURCE_TYPES];
    logic signed [AW-1:0] avail_save_reg [RESOURCE_TYPES];
    logic signed [WW-1:0] work_reg [RESOURCE_TYPES];
    logic [ROW_W-1:0]   old_row_reg;
    logic [CAP-1:0]     fin_reg;
    logic [3:0]         order_reg [CAP];
    logic [4:0]         found_reg;
    logic [3:0]         j_reg;
    logic [3:0]         pass_reg;
    logic [3:0]         k_reg;

    // row memory
    logic             st_we;
    logic [PAW-1:0]   st_waddr;
    logic [ROW_W-1:0] st_wdata;
    logic             st_re;
    logic [PAW-1:0]   st_raddr;
    logic [ROW_W-1:0] st_rdata;

    bsa_store #(
        .ROWS  (MAX_PROCESSES),
        .ROW_W (ROW_W)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // output register
    logic          out_push;
    logic          out_free;
    bsa_pkg::rsp_t out_item;

    bsa_outreg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .din       (out_item),
        .free      (out_free),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    assign cmd_stall = (state_reg != S_IDLE);

    // request vector of the latched item
    logic [7:0] req_a [6];
    assign req_a[0] = cmd_reg.req_0;
    assign req_a[1] = cmd_reg.req_1;
    assign req_a[2] = cmd_reg.req_2;
    assign req_a[3] = cmd_reg.req_3;
    assign req_a[4] = cmd_reg.req_4;
    assign req_a[5] = cmd_reg.req_5;

    // per-resource checks on the row just read
    logic [7:0]         alloc_e [RESOURCE_TYPES];
    logic [7:0]         need_e  [RESOURCE_TYPES];
    logic               over_need;
    logic               over_avail;
    logic [ROW_W-1:0]   grant_row;
    logic [ROW_W-1:0]   load_row;
    logic               fits;
    logic signed [WW-1:0] work_next [RESOURCE_TYPES];
    logic signed [AW+1:0] load_sum;
    logic signed [AW-1:0] load_sat;
    logic [7:0]         old_alloc;

    always_comb
    begin
        over_need  = 1'b0;
        over_avail = 1'b0;
        grant_row  = st_rdata;
        load_row   = st_rdata;
        old_alloc  = 8'd0;
        fits       = !fin_reg[j_reg[CW-1:0]];
        for (int r = 0; r < RESOURCE_TYPES; r++)
        begin
            alloc_e[r]   = st_rdata[r*8 +: 8];
            need_e[r]    = st_rdata[HALF + r*8 +: 8];
            work_next[r] = work_reg[r];
            if (r < 32'(m_eff))
            begin
                if (req_a[r] > need_e[r])
                    over_need = 1'b1;
                if ($signed({5'b0, req_a[r]}) > avail_reg[r])
                    over_avail = 1'b1;
                grant_row[r*8 +: 8]        = alloc_e[r] + req_a[r];
                grant_row[HALF + r*8 +: 8] = need_e[r] - req_a[r];
                if ($signed({6'b0, need_e[r]}) > work_reg[r])
                    fits = 1'b0;
            end
            if (r == 32'(cmd_reg.resource))
            begin
                old_alloc                 = alloc_e[r];
                load_row[r*8 +: 8]        = cmd_reg.alloc_amount;
                load_row[HALF + r*8 +: 8] = cmd_reg.amount - cmd_reg.alloc_amount;
            end
        end
        for (int r = 0; r < RESOURCE_TYPES; r++)
        begin
            if (fits && r < 32'(m_eff))
                work_next[r] = work_reg[r] + $signed({6'b0, alloc_e[r]});
        end
    end

    // available count after a reload, saturating
    logic signed [AW-1:0] avail_sel;
    always_comb
    begin
        avail_sel = avail_reg[0];
        for (int r = 0; r < RESOURCE_TYPES; r++)
        begin
            if (r == 32'(cmd_reg.resource))
                avail_sel = avail_reg[r];
        end
        load_sum = $signed({{2{avail_sel[AW-1]}}, avail_sel})
                 + $signed({7'b0, old_alloc}) - $signed({7'b0, cmd_reg.alloc_amount});
        if (load_sum > $signed(15'd4095))
            load_sat = 13'sd4095;
        else if (load_sum < -$signed(15'd4096))
            load_sat = -13'sd4096;
        else
            load_sat = load_sum[AW-1:0];
    end

    // walk bookkeeping
    logic       j_is_last;
    logic       walk_done;
    logic [4:0] found_next;
    logic [3:0] j_next;
    logic       walk_safe;

    assign j_is_last  = (5'(j_reg) + 5'd1 == n_eff);
    assign walk_done  = j_is_last && (5'(pass_reg) + 5'd1 == n_eff);
    assign found_next = fits ? found_reg + 5'd1 : found_reg;
    assign j_next     = j_is_last ? 4'd0 : j_reg + 4'd1;
    assign walk_safe  = (found_next == n_eff);

    // memory port selection
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = PAW'(cmd_reg.process);
        st_wdata = grant_row;
        st_re    = 1'b0;
        st_raddr = PAW'(cmd.process);
        case (state_reg)
            S_IDLE:
            begin
                st_re = cmd_valid;
            end
            S_LD_CHK:
            begin
                st_we    = 1'b1;
                st_wdata = load_row;
            end
            S_REQ_CHK:
            begin
                st_we = !over_need && !over_avail;
            end
            S_WALK_INIT:
            begin
                st_re    = 1'b1;
                st_raddr = '0;
            end
            S_WALK:
            begin
                st_re    = !walk_done;
                st_raddr = PAW'(j_next);
            end
            S_ROLLBACK:
            begin
                st_we    = 1'b1;
                st_wdata = old_row_reg;
            end
            default:
            begin
                st_re = 1'b0;
            end
        endcase
    end

    // result item selection
    logic k_is_last;
    assign k_is_last = (5'(k_reg) + 5'd1 == n_eff);

    always_comb
    begin
        out_push = 1'b0;
        out_item = '{status: status_reg, safe: 1'b0, seq_process: 4'd0, last: 1'b1};
        case (state_reg)
            S_RESULT:
            begin
                out_push = 1'b1;
            end
            S_EMIT:
            begin
                out_push = 1'b1;
                out_item = '{status: bsa_pkg::ST_OK, safe: 1'b1,
                             seq_process: order_reg[k_reg[CW-1:0]], last: k_is_last};
            end
            default:
            begin
                out_push = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pcount_reg <= 5'd1;
            rcount_reg <= 3'd6;
            found_reg  <= '0;
            fin_reg    <= '0;
            for (int r = 0; r < RESOURCE_TYPES; r++)
                avail_reg[r] <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    bsa_pkg::CFG_PROC_COUNT: pcount_reg <= cfg_data;
                    bsa_pkg::CFG_RES_COUNT:  rcount_reg <= cfg_data[2:0];
                    default:                 pcount_reg <= pcount_reg;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg    <= cmd;
                        is_req_reg <= (cmd.kind == bsa_pkg::KIND_REQUEST);
                        status_reg <= bsa_pkg::ST_OK;
                        case (cmd.kind)
                            bsa_pkg::KIND_SET_AVAIL:
                            begin
                                state_reg <= S_RESULT;
                                if (cmd.resource >= m_eff)
                                    status_reg <= bsa_pkg::ST_BAD_INDEX;
                                else
                                    avail_reg[cmd.resource] <= AW'(cmd.amount);
                            end
                            bsa_pkg::KIND_LOAD:
                            begin
                                if (5'(cmd.process) >= n_eff || cmd.resource >= m_eff)
                                begin
                                    status_reg <= bsa_pkg::ST_BAD_INDEX;
                                    state_reg  <= S_RESULT;
                                end
                                else if (cmd.alloc_amount > cmd.amount)
                                begin
                                    status_reg <= bsa_pkg::ST_ALLOC_MAX;
                                    state_reg  <= S_RESULT;
                                end
                                else
                                    state_reg <= S_LD_CHK;
                            end
                            bsa_pkg::KIND_REQUEST:
                            begin
                                if (5'(cmd.process) >= n_eff)
                                begin
                                    status_reg <= bsa_pkg::ST_BAD_INDEX;
                                    state_reg  <= S_RESULT;
                                end
                                else
                                    state_reg <= S_REQ_CHK;
                            end
                            default:
                            begin
                                state_reg <= S_WALK_INIT;
                            end
                        endcase
                    end
                end
                S_LD_CHK:
                begin
                    avail_reg[cmd_reg.resource] <= load_sat;
                    state_reg <= S_RESULT;
                end
                S_REQ_CHK:
                begin
                    if (over_need)
                    begin
                        status_reg <= bsa_pkg::ST_OVER_NEED;
                        state_reg  <= S_RESULT;
                    end
                    else if (over_avail)
                    begin
                        status_reg <= bsa_pkg::ST_MUST_WAIT;
                        state_reg  <= S_RESULT;
                    end
                    else
                    begin
                        // tentative grant, old row and counts kept for rollback
                        old_row_reg <= st_rdata;
                        for (int r = 0; r < RESOURCE_TYPES; r++)
                        begin
                            avail_save_reg[r] <= avail_reg[r];
                            if (r < 32'(m_eff))
                                avail_reg[r] <= avail_reg[r] - $signed({5'b0, req_a[r]});
                        end
                        state_reg <= S_WALK_INIT;
                    end
                end
                S_WALK_INIT:
                begin
                    for (int r = 0; r < RESOURCE_TYPES; r++)
                        work_reg[r] <= WW'(avail_reg[r]);
                    fin_reg   <= '0;
                    found_reg <= '0;
                    j_reg     <= 4'd0;
                    pass_reg  <= 4'd0;
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (fits)
                    begin
                        for (int r = 0; r < RESOURCE_TYPES; r++)
                            work_reg[r] <= work_next[r];
                        fin_reg[j_reg[CW-1:0]]       <= 1'b1;
                        order_reg[found_reg[CW-1:0]] <= j_reg;
                    end
                    found_reg <= found_next;
                    j_reg     <= j_next;
                    if (j_is_last)
                        pass_reg <= pass_reg + 4'd1;
                    if (walk_done)
                    begin
                        k_reg <= 4'd0;
                        if (walk_safe)
                            state_reg <= S_EMIT;
                        else if (is_req_reg)
                            state_reg <= S_ROLLBACK;
                        else
                        begin
                            status_reg <= bsa_pkg::ST_OK;
                            state_reg  <= S_RESULT;
                        end
                    end
                end
                S_ROLLBACK:
                begin
                    for (int r = 0; r < RESOURCE_TYPES; r++)
                        avail_reg[r] <= avail_save_reg[r];
                    status_reg <= bsa_pkg::ST_UNSAFE;
                    state_reg  <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        k_reg <= k_reg + 4'd1;
                        if (k_is_last)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // while walking, the walk never finds more processes than are in use
    `BSA_CHECK(a_found_bound, state_reg != S_WALK || found_reg <= n_eff)
    // no row write while the walk is reading rows
    `BSA_CHECK(a_no_write_in_walk, !(st_we && state_reg == S_WALK))
    // the final item of a safe sequence returns the sequencer to idle
    `BSA_CHECK_NEXT(a_emit_end, state_reg == S_EMIT && out_free && k_is_last,
                    state_reg == S_IDLE)

endmodule

/* sv/bsa_store.sv */
// per-process row memory: allocation and remaining need of every resource
// uses nothing from the package; one write port, one registered read port
module bsa_store #(
    parameter int ROWS  = 16,
    parameter int ROW_W = 96
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    we,
    input  logic [$clog2(ROWS)-1:0] waddr,
    input  logic [ROW_W-1:0]        wdata,
    input  logic                    re,
    input  logic [$clog2(ROWS)-1:0] raddr,
    output logic [ROW_W-1:0]        rdata
);

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROWS-1:0]  written_reg;
    logic [ROW_W-1:0] rdata_reg;
    logic             rvalid_reg;

    // rows never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            if (we)
                written_reg[waddr] <= 1'b1;
            if (re)
                rvalid_reg <= written_reg[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

/* sv/bsa_outreg.sv */
// result output register between the sequencer and the result channel
// depends on bsa_pkg for the result item type
module bsa_outreg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bsa_pkg::rsp_t din,
    output logic          free,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bsa_pkg::rsp_t rsp
);

    logic          valid_reg;
    bsa_pkg::rsp_t data_reg;

    assign free      = !valid_reg || !rsp_stall;
    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= push;
    end

    always_ff @(posedge clk)
    begin
        if (free && push)
            data_reg <= din;
    end

endmodule
